// File: src/cvfc_pkg.sv
`default_nettype none

package cvfc_pkg;

  // Chain and frame geometry.
  localparam int NUM_CHIPS      = 2;
  localparam int CELLS_PER_CHIP = 16;
  localparam int FRAME_BYTES    = 8;
  localparam int GROUP_CELLS    = 3;
  localparam int DATA_BYTES     = 6;
  localparam int LAST_GROUP     = 5;

  // Cell store geometry.
  localparam int STORE_DEPTH = NUM_CHIPS * CELLS_PER_CHIP;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // PEC15 polynomial and seed.
  localparam logic [14:0] CRC_POLY = 15'h4599;
  localparam logic [14:0] CRC_SEED = 15'd16;

  // Pack sum saturates at the top of its field.
  localparam logic [21:0] PACK_MAX = 22'h3FFFFF;

  // One received word: a response byte with its framing.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic [2:0] group_index;
    logic       frame_start;
  } rx_word_t;

  // One result word, given at every frame end.
  typedef struct packed {
    logic [2:0]  chip_index;
    logic [2:0]  group_done;
    logic        pec_ok;
    logic        summary_valid;
    logic [15:0] min_cell;
    logic [15:0] max_cell;
    logic [21:0] pack_sum;
    logic [19:0] segment_sum;
    logic        sweep_error;
  } result_t;

  // Write request into the cell store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       data;
  } store_wr_t;

  // Advance the PEC15 remainder by one data byte, most significant bit first.
  function automatic logic [14:0] crc15_byte(input logic [14:0] crc_in,
                                             input logic [7:0]  data);
    logic [14:0] rem;
    logic        fb;
    rem = crc_in;
    for (int b = 7; b >= 0; b--) begin
      fb  = data[b] ^ rem[14];
      rem = {rem[13:0], 1'b0};
      if (fb) begin
        rem = rem ^ CRC_POLY;
      end
    end
    return rem;
  endfunction

endpackage

`default_nettype wire

// File: src/cell_voltage_frame_checker.sv
`default_nettype none

// Cell voltage frame checker. Takes the response bytes of a daisy-chained
// cell voltage register-group read, one byte per word, and gives one result
// word at the end of every eight-byte chip frame with the chip, the group
// and the PEC15 verdict. Voltages go into a cell store whether or not the
// PEC matches; after the last chip's frame of group F the result also carries
// the minimum, maximum, saturated pack sum and the selected chip's sum. The
// PEC15 is updated one byte per cycle, so bytes inside a frame are taken one
// per cycle. After the last byte of a frame, input is stalled while the
// voltages are written through the store's single write port (three cells,
// one for group F, none for a chip or group outside the store), then on a
// closing frame while the store is scanned through its single read port,
// then while the result register is loaded, for as long as the previous
// result word is still held by the stall.
// A result waiting to be taken does not hold off bytes that do not end a
// frame. The store needs no clearing pass after reset.
module cell_voltage_frame_checker
  import cvfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  wire rx_word_t   rx,
  input  wire logic       segment_select_write,
  input  wire logic [2:0] segment_select_data,
  output logic            result_valid,
  input  wire logic       result_stall,
  output result_t         result
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WRITE = 4'b0010,
    S_SCAN  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  state_t state;
  state_t state_next;

  logic [2:0]  segment_select;
  logic [2:0]  byte_position;
  logic [2:0]  chip_counter;
  logic        error_seen;
  logic [14:0] crc;
  logic [63:0] frame_bytes;

  // Frame held for write-back and report.
  logic [2:0] f_chip;
  logic [2:0] f_group;
  logic       f_ok;
  logic       f_close;
  logic       f_err;
  logic [1:0] wr_count;

  // Scan and accumulation.
  logic              scan_issue;
  logic              scan_start;
  logic [ADDR_W-1:0] scan_addr;
  logic              acc_en;
  logic [ADDR_W-1:0] acc_idx;
  logic [6:0]        acc_full;
  logic [15:0]       min_acc;
  logic [15:0]       max_acc;
  logic [21:0]       pack_acc;
  logic [19:0]       seg_acc;
  logic [22:0]       pack_add;
  logic [21:0]       pack_sat;
  logic              seg_hit;
  logic [15:0]       rd_data;

  // Decode of the incoming word.
  logic        byte_accept;
  logic [2:0]  eff_pos;
  logic [2:0]  eff_chip;
  logic        eff_err;
  logic        frame_end;
  logic        pec_match;
  logic        store_en;
  logic        close_now;
  logic        wr_last;
  logic [4:0]  cell_full;
  logic [6:0]  wr_full;
  logic [15:0] wr_volt;
  logic        result_free;
  store_wr_t   wr;

  assign byte_stall  = (state != S_IDLE);
  assign byte_accept = byte_valid && !byte_stall;
  assign result_free = !result_valid || !result_stall;

  // A frame start restarts the byte and chip position with this byte.
  assign eff_pos   = rx.frame_start ? 3'd0 : byte_position;
  assign eff_chip  = rx.frame_start ? 3'd0 : chip_counter;
  assign eff_err   = (rx.frame_start && rx.group_index == 3'd0) ? 1'b0 : error_seen;
  assign frame_end = (eff_pos == 3'(FRAME_BYTES - 1));
  assign pec_match = ({crc, 1'b0} == {frame_bytes[7:0], rx.rx_byte});
  assign store_en  = ({1'b0, eff_chip} < 4'(NUM_CHIPS)) &&
                     (rx.group_index <= 3'(LAST_GROUP));
  assign close_now = (rx.group_index == 3'(LAST_GROUP)) &&
                     (eff_chip == 3'(NUM_CHIPS - 1));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_select <= 3'd0;
    end else if (segment_select_write) begin
      segment_select <= segment_select_data;
    end
  end

  // Frame assembly and running PEC15 over the data bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 3'd0;
      chip_counter  <= 3'd0;
      error_seen    <= 1'b0;
    end else if (byte_accept) begin
      if (frame_end) begin
        byte_position <= 3'd0;
        chip_counter  <= eff_chip + 3'd1;
        error_seen    <= close_now ? 1'b0 : (eff_err || !pec_match);
      end else begin
        byte_position <= eff_pos + 3'd1;
        chip_counter  <= eff_chip;
        error_seen    <= eff_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept) begin
      frame_bytes <= {frame_bytes[55:0], rx.rx_byte};
      if (eff_pos < 3'(DATA_BYTES)) begin
        crc <= crc15_byte((eff_pos == 3'd0) ? CRC_SEED : crc, rx.rx_byte);
      end
      if (frame_end) begin
        f_chip  <= eff_chip;
        f_group <= rx.group_index;
        f_ok    <= pec_match;
        f_close <= close_now;
        f_err   <= eff_err || !pec_match;
      end
    end
  end

  // Write-back of the frame's voltages, one cell per cycle.
  assign wr_last   = (f_group == 3'(LAST_GROUP)) || (wr_count == 2'd2);
  assign cell_full = {1'b0, f_group, 1'b0} + {2'b0, f_group} + {3'b0, wr_count};
  assign wr_full   = {f_chip, cell_full[3:0]};

  always_comb begin
    case (wr_count)
      2'd0:    wr_volt = {frame_bytes[55:48], frame_bytes[63:56]};
      2'd1:    wr_volt = {frame_bytes[39:32], frame_bytes[47:40]};
      2'd2:    wr_volt = {frame_bytes[23:16], frame_bytes[31:24]};
      default: wr_volt = 16'd0;
    endcase
  end

  assign wr.en   = (state == S_WRITE);
  assign wr.addr = wr_full[ADDR_W-1:0];
  assign wr.data = wr_volt;

  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      wr_count <= wr_count + 2'd1;
    end else begin
      wr_count <= 2'd0;
    end
  end

  // Sequencer: writes finish before the scan starts, so reads never meet
  // a pending write to the same cell.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (byte_accept && frame_end) begin
          if (store_en) begin
            state_next = S_WRITE;
          end else if (close_now) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_WRITE: begin
        if (wr_last) begin
          state_next = f_close ? S_SCAN : S_EMIT;
        end
      end
      S_SCAN: begin
        if (acc_en && acc_idx == LAST_ADDR) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (result_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign scan_start = (state_next == S_SCAN) && (state != S_SCAN);

  // Read addresses go out one per cycle; data comes back through the store's read register.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_issue <= 1'b0;
      acc_en     <= 1'b0;
    end else begin
      acc_en <= scan_issue;
      if (scan_start) begin
        scan_issue <= 1'b1;
      end else if (scan_issue && scan_addr == LAST_ADDR) begin
        scan_issue <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_idx <= scan_addr;
    if (scan_start) begin
      scan_addr <= '0;
    end else if (scan_issue && scan_addr != LAST_ADDR) begin
      scan_addr <= scan_addr + 1'b1;
    end
  end

  cvfc_cell_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  // Minimum, maximum and sums over the returning cells.
  assign acc_full = 7'(acc_idx);
  assign seg_hit  = (acc_full[6:4] == segment_select);
  assign pack_add = {1'b0, pack_acc} + 23'(rd_data);
  assign pack_sat = pack_add[22] ? PACK_MAX : pack_add[21:0];

  always_ff @(posedge clk) begin
    if (acc_en) begin
      if (acc_idx == '0) begin
        min_acc  <= rd_data;
        max_acc  <= rd_data;
        pack_acc <= 22'(rd_data);
        seg_acc  <= seg_hit ? 20'(rd_data) : 20'd0;
      end else begin
        if (rd_data < min_acc) begin
          min_acc <= rd_data;
        end
        if (rd_data > max_acc) begin
          max_acc <= rd_data;
        end
        pack_acc <= pack_sat;
        if (seg_hit) begin
          seg_acc <= seg_acc + 20'(rd_data);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_EMIT && result_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && result_free) begin
      result.chip_index    <= f_chip;
      result.group_done    <= f_group;
      result.pec_ok        <= f_ok;
      result.summary_valid <= f_close;
      result.min_cell      <= f_close ? min_acc : 16'd0;
      result.max_cell      <= f_close ? max_acc : 16'd0;
      result.pack_sum      <= f_close ? pack_acc : 22'd0;
      result.segment_sum   <= f_close ? seg_acc : 20'd0;
      result.sweep_error   <= f_err;
    end
  end

endmodule

`default_nettype wire

// File: src/cvfc_cell_store.sv
`default_nettype none

module cvfc_cell_store
  import cvfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire store_wr_t         wr,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [15:0]       rd_data
);

  logic [15:0]            mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] written;
  logic [15:0]            rd_raw;
  logic                   rd_written;

  // Single write port and single registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_raw     <= mem[rd_addr];
    rd_written <= written[rd_addr];
  end

  // One flag per cell; reset marks the whole store as holding zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

  // A cell never written since reset reads as zero.
  assign rd_data = rd_written ? rd_raw : 16'd0;

endmodule

`default_nettype wire

// File: src/cvfc_checker.sv
`default_nettype none

module cvfc_checker
  import cvfc_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     byte_stall,
  input wire logic     result_valid,
  input wire logic     result_stall,
  input wire result_t  result
);

  // Straight out of reset the block takes bytes and holds no result.
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) && !rst |-> !byte_stall && !result_valid)
    else $error("block not idle after reset");

  // A result word waiting on the stall holds still.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  // Only the last chip of group F closes a sweep.
  a_close_place: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.summary_valid |->
      result.group_done == 3'(LAST_GROUP) && result.chip_index == 3'(NUM_CHIPS - 1))
    else $error("summary on a frame that does not close the sweep");

  // Summary fields are zero unless the word closes the sweep.
  a_summary_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.summary_valid |->
      result.min_cell == 16'd0 && result.max_cell == 16'd0 &&
      result.pack_sum == 22'd0 && result.segment_sum == 20'd0)
    else $error("summary fields set on an ordinary frame");

  // The summaries are mutually consistent.
  a_summary_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.summary_valid |->
      result.min_cell <= result.max_cell &&
      22'(result.segment_sum) <= result.pack_sum)
    else $error("inconsistent summary values");

endmodule

bind cell_voltage_frame_checker cvfc_checker u_cvfc_checker (.*);

`default_nettype wire

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cvfc_pkg::*;

  // Enough quiet cycles for a frame end, a full store scan and the result load.
  localparam int SETTLE_CYCLES = 2 * (STORE_DEPTH + 8);
  localparam int CYCLE_LIMIT   = 400000;

  // One row of the directed table: a chip frame, possibly cut short.
  typedef struct {
    logic [2:0]  group;
    bit          start;
    logic [15:0] v0;
    logic [15:0] v1;
    logic [15:0] v2;
    bit          bad_pec;
    int          len;
    bit          typed;
    result_t     want;
  } frame_row_t;

  logic        clk;
  logic        rst                  = 1'b1;
  logic        byte_valid           = 1'b0;
  logic        byte_stall;
  rx_word_t    rx                   = '0;
  logic        segment_select_write = 1'b0;
  logic [2:0]  segment_select_data  = 3'd0;
  logic        result_valid;
  logic        result_stall         = 1'b0;
  result_t     result;

  int          send_idle_pct = 16;
  int          recv_idle_pct = 73;
  int          bytes_sent    = 0;
  int          mismatch_count = 0;

  result_t     pending_frame_results[$];
  frame_row_t  directed_rows[$];

  // Shadow copy of the block's state.
  logic [15:0] cell_image [STORE_DEPTH];
  logic [63:0] frame_image    = '0;
  int unsigned byte_slot      = 0;
  logic [2:0]  chip_slot      = 3'd0;
  bit          sweep_failed   = 1'b0;
  logic [2:0]  segment_choice = 3'd0;

  cell_voltage_frame_checker u_dut (
    .clk                  (clk),
    .rst                  (rst),
    .byte_valid           (byte_valid),
    .byte_stall           (byte_stall),
    .rx                   (rx),
    .segment_select_write (segment_select_write),
    .segment_select_data  (segment_select_data),
    .result_valid         (result_valid),
    .result_stall         (result_stall),
    .result               (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // PEC15 over six data bytes, most significant bit first, shifted left by one.
  function automatic logic [15:0] pec15_over(input logic [47:0] data);
    logic [14:0] rem;
    logic        fb;
    rem = CRC_SEED;
    for (int k = 47; k >= 0; k--) begin
      fb  = data[k] ^ rem[14];
      rem = {rem[13:0], 1'b0};
      if (fb) begin
        rem = rem ^ CRC_POLY;
      end
    end
    return {rem, 1'b0};
  endfunction

  // Takes one accepted word into the shadow state; gives 1 and the expected
  // result word when the word closes a chip frame.
  function automatic bit advance_frame_model(input rx_word_t w, output result_t r);
    logic [7:0]  fb [FRAME_BYTES];
    int          cells;
    int          base;
    int unsigned total;
    int unsigned seg;
    logic [15:0] lo;
    logic [15:0] hi;
    bit          ok;
    bit          close;
    r = '0;
    if (w.frame_start) begin
      byte_slot   = 0;
      chip_slot   = 3'd0;
      frame_image = '0;
      if (w.group_index == 3'd0) begin
        sweep_failed = 1'b0;
      end
    end
    frame_image = {frame_image[55:0], w.rx_byte};
    if (byte_slot < FRAME_BYTES - 1) begin
      byte_slot++;
      return 1'b0;
    end
    byte_slot = 0;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      fb[i] = frame_image[63 - 8 * i -: 8];
    end
    ok = (pec15_over(frame_image[63:16]) == frame_image[15:0]);
    if (!ok) begin
      sweep_failed = 1'b1;
    end

    // Voltages are stored whatever the PEC verdict; group F keeps only one.
    if (chip_slot < NUM_CHIPS && w.group_index <= LAST_GROUP) begin
      base  = chip_slot * CELLS_PER_CHIP + w.group_index * GROUP_CELLS;
      cells = (w.group_index == LAST_GROUP) ? 1 : GROUP_CELLS;
      for (int i = 0; i < cells; i++) begin
        cell_image[base + i] = {fb[2 * i + 1], fb[2 * i]};
      end
    end

    close = (w.group_index == LAST_GROUP) && (chip_slot == NUM_CHIPS - 1);
    r.chip_index    = chip_slot;
    r.group_done    = w.group_index;
    r.pec_ok        = ok;
    r.summary_valid = close;

    // The closing frame scans the whole store.
    if (close) begin
      lo    = cell_image[0];
      hi    = cell_image[0];
      total = 0;
      seg   = 0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        if (cell_image[i] < lo) begin
          lo = cell_image[i];
        end
        if (cell_image[i] > hi) begin
          hi = cell_image[i];
        end
        total += cell_image[i];
        if (i / CELLS_PER_CHIP == segment_choice) begin
          seg += cell_image[i];
        end
      end
      r.min_cell    = lo;
      r.max_cell    = hi;
      r.pack_sum    = (total > PACK_MAX) ? PACK_MAX : total[21:0];
      r.segment_sum = seg[19:0];
    end
    r.sweep_error = sweep_failed;
    if (close) begin
      sweep_failed = 1'b0;
    end
    chip_slot = chip_slot + 3'd1;
    return 1'b1;
  endfunction

  // A result word that carries no summaries.
  function automatic result_t frame_only(input logic [2:0] chip, input logic [2:0] group,
                                         input bit ok, input bit err);
    result_t r;
    r             = '0;
    r.chip_index  = chip;
    r.group_done  = group;
    r.pec_ok      = ok;
    r.sweep_error = err;
    return r;
  endfunction

  // Mostly spread values, with the rails now and then.
  function automatic logic [15:0] random_cell_volts();
    case ($urandom_range(7))
      0: begin
        return 16'h0000;
      end
      1: begin
        return 16'hFFFF;
      end
      default: begin
        return 16'($urandom);
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_row(input logic [2:0] group, input bit start, input logic [15:0] v0,
                         input logic [15:0] v1, input logic [15:0] v2, input bit bad_pec,
                         input int len, input bit typed, input result_t want);
    frame_row_t row;
    row.group   = group;
    row.start   = start;
    row.v0      = v0;
    row.v1      = v1;
    row.v2      = v2;
    row.bad_pec = bad_pec;
    row.len     = len;
    row.typed   = typed;
    row.want    = want;
    directed_rows.push_back(row);
  endtask

  // Offers one word, idling first at the current rate, and records what it causes.
  task automatic send_word(input rx_word_t w, input bit use_typed, input result_t typed);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    rx         <= w;
    @(posedge clk);
    while (byte_stall) begin
      @(posedge clk);
    end
    bytes_sent++;
    if (advance_frame_model(w, predicted)) begin
      pending_frame_results.push_back(use_typed ? typed : predicted);
    end
  endtask

  // Sends the first len bytes of a chip frame built from three voltages.
  task automatic send_frame(input logic [2:0] group, input bit start, input logic [15:0] v0,
                            input logic [15:0] v1, input logic [15:0] v2, input bit bad_pec,
                            input int len, input bit typed, input result_t want);
    logic [63:0] frame;
    logic [15:0] pec;
    rx_word_t    w;
    frame[63:16] = {v0[7:0], v0[15:8], v1[7:0], v1[15:8], v2[7:0], v2[15:8]};
    pec          = pec15_over(frame[63:16]);
    if (bad_pec) begin
      pec = pec ^ (16'd1 << $urandom_range(15));
    end
    frame[15:0] = pec;
    for (int k = 0; k < len; k++) begin
      w.rx_byte     = frame[63 - 8 * k -: 8];
      w.group_index = group;
      w.frame_start = start && (k == 0);
      send_word(w, typed && (k == FRAME_BYTES - 1), want);
    end
  endtask

  // Drops valid and waits until every expected result word has been taken.
  task automatic hold_until_drained(input int extra_cycles);
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending_frame_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (extra_cycles) @(posedge clk);
  endtask

  task automatic write_segment(input logic [2:0] value);
    segment_select_write <= 1'b1;
    segment_select_data  <= value;
    @(posedge clk);
    segment_select_write <= 1'b0;
    segment_choice = value;
  endtask

  // Mostly whole sweeps with random voltages, the rest noise and broken frames.
  task automatic run_random_traffic(input int byte_target);
    int       first_byte;
    int       kind;
    int       chips;
    rx_word_t w;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < byte_target) begin
      kind = $urandom_range(99);
      if (kind < 78) begin
        for (int g = 0; g <= LAST_GROUP; g++) begin
          chips = ($urandom_range(9) == 0) ? $urandom_range(10, 1) : NUM_CHIPS;
          for (int c = 0; c < chips; c++) begin
            send_frame(3'(g), c == 0, random_cell_volts(), random_cell_volts(),
                       random_cell_volts(), $urandom_range(15) == 0, FRAME_BYTES,
                       1'b0, '0);
          end
          if ($urandom_range(39) == 0) begin
            hold_until_drained(0);
          end
        end
      end else if (kind < 92) begin
        repeat ($urandom_range(24, 1)) begin
          w.rx_byte     = 8'($urandom);
          w.group_index = 3'($urandom);
          w.frame_start = ($urandom_range(7) == 0);
          send_word(w, 1'b0, '0);
        end
      end else begin
        send_frame(3'($urandom_range(7)), 1'b1, random_cell_volts(), random_cell_volts(),
                   random_cell_volts(), $urandom_range(3) == 0,
                   $urandom_range(FRAME_BYTES, 1), 1'b0, '0);
      end
    end
  endtask

  // Result side: check each taken word, then choose the next stall.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_frame_results.size() == 0) begin
        flag_mismatch("result word with none expected", 1, 0);
      end else begin
        want = pending_frame_results.pop_front();
        if (result.chip_index !== want.chip_index)
          flag_mismatch("chip_index", result.chip_index, want.chip_index);
        if (result.group_done !== want.group_done)
          flag_mismatch("group_done", result.group_done, want.group_done);
        if (result.pec_ok !== want.pec_ok)
          flag_mismatch("pec_ok", result.pec_ok, want.pec_ok);
        if (result.summary_valid !== want.summary_valid)
          flag_mismatch("summary_valid", result.summary_valid, want.summary_valid);
        if (result.min_cell !== want.min_cell)
          flag_mismatch("min_cell", result.min_cell, want.min_cell);
        if (result.max_cell !== want.max_cell)
          flag_mismatch("max_cell", result.max_cell, want.max_cell);
        if (result.pack_sum !== want.pack_sum)
          flag_mismatch("pack_sum", result.pack_sum, want.pack_sum);
        if (result.segment_sum !== want.segment_sum)
          flag_mismatch("segment_sum", result.segment_sum, want.segment_sum);
        if (result.sweep_error !== want.sweep_error)
          flag_mismatch("sweep_error", result.sweep_error, want.sweep_error);
      end
    end
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog on the whole run.
  initial begin
    for (int cycle = 0; cycle < CYCLE_LIMIT; cycle++) begin
      @(posedge clk);
    end
    $display("cell_voltage_frame_checker test failed");
    $finish;
  end

  initial begin
    result_t full_scale;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      cell_image[i] = 16'h0000;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: a sweep with odd cases, stray groups, then a full-scale sweep.
    full_scale               = frame_only(3'd1, 3'd5, 1'b1, 1'b0);
    full_scale.summary_valid = 1'b1;
    full_scale.min_cell      = 16'hFFFF;
    full_scale.max_cell      = 16'hFFFF;
    full_scale.pack_sum      = 22'(STORE_DEPTH * 65535);
    full_scale.segment_sum   = 20'(CELLS_PER_CHIP * 65535);

    add_row(3'd0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8, 1'b1,
            frame_only(3'd0, 3'd0, 1'b1, 1'b0));
    add_row(3'd0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 8, 1'b1,
            frame_only(3'd1, 3'd0, 1'b1, 1'b0));
    // An abandoned read, restarted by the next frame start.
    add_row(3'd1, 1'b1, 16'h1111, 16'h2222, 16'h3333, 1'b0, 3, 1'b0, '0);
    add_row(3'd1, 1'b1, 16'h8001, 16'h7FFF, 16'h00FF, 1'b1, 8, 1'b1,
            frame_only(3'd0, 3'd1, 1'b0, 1'b1));
    add_row(3'd1, 1'b0, 16'h0F0F, 16'hF0F0, 16'h5A5A, 1'b0, 8, 1'b0, '0);
    add_row(3'd2, 1'b1, 16'h1234, 16'h5678, 16'h9ABC, 1'b0, 8, 1'b0, '0);
    add_row(3'd2, 1'b0, 16'hA5A5, 16'h0001, 16'hFFFE, 1'b0, 8, 1'b0, '0);
    add_row(3'd3, 1'b1, 16'h4000, 16'hC000, 16'h0100, 1'b0, 8, 1'b0, '0);
    add_row(3'd3, 1'b0, 16'h3E80, 16'h4268, 16'h2EE0, 1'b0, 8, 1'b0, '0);
    add_row(3'd4, 1'b1, 16'h0002, 16'h7FFE, 16'h8000, 1'b0, 8, 1'b0, '0);
    add_row(3'd4, 1'b0, 16'hDEAD, 16'hBEEF, 16'h0F00, 1'b0, 8, 1'b0, '0);
    add_row(3'd5, 1'b1, 16'h3A98, 16'hFFFF, 16'h0000, 1'b0, 8, 1'b0, '0);
    add_row(3'd5, 1'b0, 16'h1388, 16'h0001, 16'hFFFF, 1'b0, 8, 1'b0, '0);
    // Groups beyond F are checked and reported but store nothing.
    add_row(3'd6, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8, 1'b1,
            frame_only(3'd0, 3'd6, 1'b1, 1'b0));
    add_row(3'd7, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 8, 1'b1,
            frame_only(3'd1, 3'd7, 1'b0, 1'b1));
    // Full-scale sweep; a chip past the chain and group F's dropped words carry zeros.
    for (int g = 0; g <= LAST_GROUP; g++) begin
      for (int c = 0; c < ((g == 0) ? NUM_CHIPS + 1 : NUM_CHIPS); c++) begin
        if (c >= NUM_CHIPS) begin
          add_row(3'(g), 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8, 1'b1,
                  frame_only(3'(c), 3'(g), 1'b1, 1'b0));
        end else if (g == LAST_GROUP) begin
          add_row(3'(g), c == 0, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 8,
                  c == NUM_CHIPS - 1, full_scale);
        end else begin
          add_row(3'(g), c == 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 8, 1'b0, '0);
        end
      end
    end

    write_segment(3'd1);
    foreach (directed_rows[i]) begin
      send_frame(directed_rows[i].group, directed_rows[i].start, directed_rows[i].v0,
                 directed_rows[i].v1, directed_rows[i].v2, directed_rows[i].bad_pec,
                 directed_rows[i].len, directed_rows[i].typed, directed_rows[i].want);
    end
    hold_until_drained(SETTLE_CYCLES);

    // Random phases: sender light and receiver heavy, then swapped, then flat out.
    write_segment(3'd0);
    run_random_traffic(300);
    hold_until_drained(SETTLE_CYCLES);

    send_idle_pct = 73;
    recv_idle_pct = 16;
    write_segment(3'd7);
    run_random_traffic(300);
    hold_until_drained(SETTLE_CYCLES);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_segment(3'($urandom_range(7)));
    run_random_traffic(290);
    hold_until_drained(SETTLE_CYCLES);

    if (mismatch_count == 0) begin
      $display("cell_voltage_frame_checker test passed");
    end else begin
      $display("cell_voltage_frame_checker test failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/cvfc_pkg.sv
src/cvfc_cell_store.sv
src/cell_voltage_frame_checker.sv
src/cvfc_checker.sv
tb/sv/tb_top.sv
